// ----- hdl/nearest_car_elevator_dispatch_core_defines.svh -----
// Assertion helpers shared by the dispatch core.
`ifndef NEAREST_CAR_ELEVATOR_DISPATCH_CORE_DEFINES_SVH
`define NEAREST_CAR_ELEVATOR_DISPATCH_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define NCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define NCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/ncd_pkg.sv -----
package ncd_pkg;

    // Field widths fixed by the item formats.
    localparam int FLOOR_W = 6;
    localparam int COUNT_W = 4;
    localparam int CAR_W   = 3;

    // Operation codes of an input item.
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Kinds of result item.
    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Motion codes; code 3 behaves as idle and is kept.
    localparam logic [1:0] MOTION_IDLE = 2'd0;
    localparam logic [1:0] MOTION_UP   = 2'd1;
    localparam logic [1:0] MOTION_DOWN = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [FLOOR_W-1:0] request_floor;
    } t_cmd;

    typedef struct packed {
        logic               report_kind;
        logic [CAR_W-1:0]   car_index;
        logic [FLOOR_W-1:0] car_floor;
        logic [1:0]         car_motion;
        logic               arrived;
        logic               last_report;
    } t_rpt;

    // One entry of the car state memory.
    typedef struct packed {
        logic [FLOOR_W-1:0] floor;
        logic [FLOOR_W-1:0] target;
        logic [1:0]         motion;
    } t_car;

endpackage

// ----- hdl/nearest_car_elevator_dispatch_core.sv -----
// Request: the N cars in service (N from the car count) are scanned, then one assignment result follows.
// Tick: one result per cycle, one for each car in service; busy until the last of them is strobed.
// A new item is taken only while idle, after the last result of the previous item.
// The rate is set by the single read port of the car state memory: one car per cycle.
// Results are strobed for one cycle; the receiver cannot stall them.
// Synchronous active-low reset: all cars at floor zero, idle, target zero, car count 1.
`include "nearest_car_elevator_dispatch_core_defines.svh"

module nearest_car_elevator_dispatch_core #(
    parameter int MAX_CARS    = 8,
    parameter int FLOOR_COUNT = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ncd_pkg::t_cmd                i_cmd,
    output logic                         o_rpt_stb,
    output ncd_pkg::t_rpt                o_rpt,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ncd_pkg::COUNT_W-1:0]  i_cfg_data
);

    localparam int CW      = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int NW      = $clog2(MAX_CARS + 1);
    localparam int TOP_INT = (FLOOR_COUNT - 1 > 63) ? 63 : FLOOR_COUNT - 1;
    localparam logic [ncd_pkg::FLOOR_W-1:0] TOP_FLOOR = ncd_pkg::FLOOR_W'(TOP_INT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WRITE
    } t_state;

    t_state                        r_state;
    logic                          r_op;
    logic [ncd_pkg::FLOOR_W-1:0]   r_req;
    logic [ncd_pkg::COUNT_W-1:0]   r_count;
    logic [CW-1:0]                 r_idx;
    logic                          r_issue;
    logic                          r_pend;
    logic [CW-1:0]                 r_pidx;
    logic                          r_rd_vbit;
    logic [MAX_CARS-1:0]           r_valid;
    logic [CW-1:0]                 r_best_idx;
    logic [ncd_pkg::FLOOR_W-1:0]   r_best_cost;
    ncd_pkg::t_car                 r_best;
    ncd_pkg::t_car                 r_rd;
    ncd_pkg::t_car                 r_mem [MAX_CARS];
    ncd_pkg::t_rpt                 r_rpt;
    logic                          r_rpt_stb;

    logic [NW-1:0]                 w_cars;
    logic [CW-1:0]                 w_last_idx;
    logic [ncd_pkg::FLOOR_W-1:0]   w_req_sat;
    ncd_pkg::t_car                 w_cur;
    logic [ncd_pkg::FLOOR_W-1:0]   w_cost;
    ncd_pkg::t_car                 w_tick_next;
    logic                          w_arrive;
    ncd_pkg::t_car                 w_assign_next;
    logic                          w_we;
    logic [CW-1:0]                 w_waddr;
    ncd_pkg::t_car                 w_wdata;
    logic                          w_assign_rpt;

    // Cars in service: a count of zero acts as one, a count beyond the pool is clamped.
    always_comb begin
        if (r_count == '0) begin
            w_cars = NW'(1);
        end else if (32'(r_count) > MAX_CARS) begin
            w_cars = NW'(MAX_CARS);
        end else begin
            w_cars = NW'(r_count);
        end
        w_last_idx = CW'(w_cars - NW'(1));
    end

    // Requests above the top floor saturate.
    assign w_req_sat = (i_cmd.request_floor > TOP_FLOOR) ? TOP_FLOOR : i_cmd.request_floor;

    // An entry never written reads as its reset value.
    assign w_cur  = r_rd_vbit ? r_rd : '0;
    assign w_cost = (w_cur.floor > r_req) ? (w_cur.floor - r_req) : (r_req - w_cur.floor);

    // One tick step for the car whose entry was just read.
    always_comb begin
        w_tick_next = w_cur;
        w_arrive    = 1'b0;
        case (w_cur.motion)
            ncd_pkg::MOTION_UP: begin
                if (w_cur.floor < w_cur.target) begin
                    w_tick_next.floor = w_cur.floor + ncd_pkg::FLOOR_W'(1);
                end else begin
                    w_tick_next.motion = ncd_pkg::MOTION_IDLE;
                    w_arrive           = 1'b1;
                end
            end
            ncd_pkg::MOTION_DOWN: begin
                if (w_cur.floor > w_cur.target) begin
                    w_tick_next.floor = w_cur.floor - ncd_pkg::FLOOR_W'(1);
                end else begin
                    w_tick_next.motion = ncd_pkg::MOTION_IDLE;
                    w_arrive           = 1'b1;
                end
            end
            default: begin
                w_tick_next = w_cur;
            end
        endcase
    end

    // New state of the car chosen by a request.
    always_comb begin
        w_assign_next        = r_best;
        w_assign_next.target = r_req;
        if (r_best.floor < r_req) begin
            w_assign_next.motion = ncd_pkg::MOTION_UP;
        end else if (r_best.floor > r_req) begin
            w_assign_next.motion = ncd_pkg::MOTION_DOWN;
        end
    end

    // Write port of the car memory: tick write-back or the request's assignment.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pidx;
        w_wdata = w_tick_next;
        if (r_state == S_RUN && r_pend && r_op == ncd_pkg::OP_TICK) begin
            w_we = 1'b1;
        end else if (r_state == S_WRITE) begin
            w_we    = 1'b1;
            w_waddr = r_best_idx;
            w_wdata = w_assign_next;
        end
    end

    // Car state memory with a registered read at the scan pointer.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    // Sequencer, valid bits, configuration and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= ncd_pkg::OP_REQUEST;
            r_req       <= '0;
            r_count     <= ncd_pkg::COUNT_W'(1);
            r_idx       <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_pidx      <= '0;
            r_rd_vbit   <= 1'b0;
            r_valid     <= '0;
            r_best_idx  <= '0;
            r_best_cost <= '0;
            r_best      <= '0;
            r_rpt       <= '0;
            r_rpt_stb   <= 1'b0;
        end else begin
            r_rpt_stb <= 1'b0;
            r_rd_vbit <= r_valid[r_idx];
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_pend <= 1'b0;
                    if (start) begin
                        r_op    <= i_cmd.operation;
                        r_req   <= w_req_sat;
                        r_idx   <= '0;
                        r_issue <= 1'b1;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    // Issue one read a cycle until the last car in service.
                    if (r_issue) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_idx;
                        if (r_idx == w_last_idx) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end else begin
                        r_pend <= 1'b0;
                    end

                    // Consume the entry read in the previous cycle.
                    if (r_pend) begin
                        if (r_op == ncd_pkg::OP_TICK) begin
                            r_rpt_stb         <= 1'b1;
                            r_rpt.report_kind <= ncd_pkg::KIND_TICK;
                            r_rpt.car_index   <= ncd_pkg::CAR_W'(r_pidx);
                            r_rpt.car_floor   <= w_tick_next.floor;
                            r_rpt.car_motion  <= w_tick_next.motion;
                            r_rpt.arrived     <= w_arrive;
                            r_rpt.last_report <= (r_pidx == w_last_idx);
                            if (r_pidx == w_last_idx) begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            // Strictly smaller cost wins, so ties keep the lower index.
                            if (r_pidx == '0 || w_cost < r_best_cost) begin
                                r_best_idx  <= r_pidx;
                                r_best_cost <= w_cost;
                                r_best      <= w_cur;
                            end
                            if (r_pidx == w_last_idx) begin
                                r_state <= S_WRITE;
                            end
                        end
                    end
                end
                S_WRITE: begin
                    r_rpt_stb         <= 1'b1;
                    r_rpt.report_kind <= ncd_pkg::KIND_ASSIGN;
                    r_rpt.car_index   <= ncd_pkg::CAR_W'(r_best_idx);
                    r_rpt.car_floor   <= r_best.floor;
                    r_rpt.car_motion  <= w_assign_next.motion;
                    r_rpt.arrived     <= 1'b0;
                    r_rpt.last_report <= 1'b1;
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_rpt_stb   = r_rpt_stb;
    assign o_rpt       = r_rpt;

    assign w_assign_rpt = o_rpt_stb && (o_rpt.report_kind == ncd_pkg::KIND_ASSIGN);

    // A result appears only in the cycle after the sequencer was working.
    `NCD_ASSERT(a_stb_after_busy, o_rpt_stb |-> $past(r_state != S_IDLE), "result without work")
    // An assignment answer is always the single, final result of its request.
    `NCD_ASSERT(a_assign_last, w_assign_rpt |-> (o_rpt.last_report && !o_rpt.arrived), "bad answer")
    // An accepted item makes the block busy in the next cycle.
    `NCD_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item left block idle")
    // Entries in flight always belong to cars in service.
    `NCD_ASSERT(a_pend_in_range, r_pend |-> (r_pidx <= w_last_idx), "read past last car")
    // Reset leaves no result strobe behind.
    `NCD_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_rpt_stb, "strobe after reset")

endmodule
